/* hdl/ssps_pkg.sv */
// shared types, codes and constants of the spi sensor poll sequencer
package ssps_pkg;

  localparam int unsigned ADC_MAX_CHANNELS = 16;
  localparam int unsigned IMU_CHANNELS     = 7;

  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned ACNT_W  = 5;
  localparam int unsigned IMUREG_W = 7;

  localparam logic [ACNT_W-1:0]   ADC_COUNT_RESET = 5'd8;
  localparam logic [IMUREG_W-1:0] IMU_START_RESET = 7'd32;

  // read flag of the imu burst command byte
  localparam logic IMU_READ_BIT = 1'b1;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_WORD = 1'b1;

  localparam logic REG_ADC_COUNT = 1'b0;
  localparam logic REG_IMU_START = 1'b1;

  localparam logic [1:0] ADC_CS_NONE     = 2'd0;
  localparam logic [1:0] ADC_CS_ASSERT   = 2'd1;
  localparam logic [1:0] ADC_CS_RELEASE  = 2'd2;
  localparam logic [1:0] ADC_CS_REASSERT = 2'd3;

  localparam logic [1:0] IMU_CS_NONE    = 2'd0;
  localparam logic [1:0] IMU_CS_ASSERT  = 2'd1;
  localparam logic [1:0] IMU_CS_RELEASE = 2'd2;

  localparam logic SRC_ADC = 1'b0;
  localparam logic SRC_IMU = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] rx_word;
    logic        imu_int;
  } in_t;

  typedef struct packed {
    logic [1:0]  tx_count;
    logic [15:0] tx_first;
    logic [15:0] tx_second;
    logic [1:0]  adc_cs_action;
    logic [1:0]  imu_cs_action;
    logic        imu_bus_mode;
    logic        sample_valid;
    logic        sample_source;
    logic [3:0]  sample_index;
    logic [15:0] sample_value;
    logic        frame_done;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] word_counter;
    logic             in_imu_phase;
    logic             frame_active;
  } state_t;

  typedef struct packed {
    logic [ACNT_W-1:0]   adc_channel_count;
    logic [IMUREG_W-1:0] imu_burst_start_register;
  } cfg_t;

  function automatic logic [15:0] swap16(input logic [15:0] w);
    swap16 = {w[7:0], w[15:8]};
  endfunction

endpackage

/* hdl/ssps_step.sv */
// decode of one event against the sequencer state: result item and next state
module ssps_step (
  input  ssps_pkg::in_t    item_i,
  input  ssps_pkg::state_t state_i,
  input  ssps_pkg::cfg_t   cfg_i,
  output ssps_pkg::out_t   res_o,
  output ssps_pkg::state_t next_o
);

  logic [ssps_pkg::ACNT_W-1:0] n;
  logic [ssps_pkg::CNT_W-1:0]  two_n;
  logic [ssps_pkg::CNT_W-1:0]  i;
  logic [ssps_pkg::CNT_W-1:0]  j;

  always_comb begin
    // clamp channel count into the supported range
    if (cfg_i.adc_channel_count == '0) begin
      n = ssps_pkg::ACNT_W'(1);
    end else if (cfg_i.adc_channel_count > ssps_pkg::ACNT_W'(ssps_pkg::ADC_MAX_CHANNELS)) begin
      n = ssps_pkg::ACNT_W'(ssps_pkg::ADC_MAX_CHANNELS);
    end else begin
      n = cfg_i.adc_channel_count;
    end
  end

  assign two_n = {n, 1'b0};
  assign i     = state_i.word_counter;
  assign j     = i - two_n;

  always_comb begin
    res_o  = '0;
    next_o = state_i;
    if (item_i.command == ssps_pkg::CMD_TICK) begin
      if (state_i.frame_active && state_i.in_imu_phase) begin
        res_o.imu_cs_action = ssps_pkg::IMU_CS_RELEASE;
      end
      next_o.word_counter  = '0;
      next_o.in_imu_phase  = 1'b0;
      next_o.frame_active  = 1'b1;
      res_o.tx_count       = 2'd2;
      res_o.adc_cs_action  = ssps_pkg::ADC_CS_ASSERT;
    end else if (state_i.frame_active) begin
      if (i != '1) begin
        next_o.word_counter = i + ssps_pkg::CNT_W'(1);
      end
      if (!state_i.in_imu_phase) begin
        if (i >= two_n) begin
          res_o.adc_cs_action = ssps_pkg::ADC_CS_RELEASE;
          res_o.frame_done    = 1'b1;
          next_o.frame_active = 1'b0;
        end else if (i[0]) begin
          res_o.sample_valid  = 1'b1;
          res_o.sample_source = ssps_pkg::SRC_ADC;
          res_o.sample_index  = i[4:1];
          res_o.sample_value  = ssps_pkg::swap16(item_i.rx_word);
          if (i < two_n - ssps_pkg::CNT_W'(2)) begin
            res_o.tx_count      = 2'd2;
            res_o.adc_cs_action = ssps_pkg::ADC_CS_REASSERT;
          end else begin
            res_o.adc_cs_action = ssps_pkg::ADC_CS_RELEASE;
            if (item_i.imu_int) begin
              next_o.in_imu_phase = 1'b1;
              res_o.imu_cs_action = ssps_pkg::IMU_CS_ASSERT;
              res_o.tx_count      = 2'd2;
              res_o.tx_first      = {ssps_pkg::IMU_READ_BIT,
                                     cfg_i.imu_burst_start_register, 8'h00};
            end else begin
              res_o.frame_done    = 1'b1;
              next_o.frame_active = 1'b0;
            end
          end
        end
      end else begin
        if (i < two_n || j > ssps_pkg::CNT_W'(ssps_pkg::IMU_CHANNELS)) begin
          res_o.imu_cs_action = ssps_pkg::IMU_CS_RELEASE;
          res_o.frame_done    = 1'b1;
          next_o.frame_active = 1'b0;
        end else if (j == '0) begin
          res_o.tx_count = 2'd1;
        end else begin
          res_o.sample_valid  = 1'b1;
          res_o.sample_source = ssps_pkg::SRC_IMU;
          res_o.sample_index  = 4'(j - ssps_pkg::CNT_W'(1));
          res_o.sample_value  = ssps_pkg::swap16(item_i.rx_word);
          if (j < ssps_pkg::CNT_W'(ssps_pkg::IMU_CHANNELS - 1)) begin
            res_o.tx_count = 2'd1;
          end else if (j == ssps_pkg::CNT_W'(ssps_pkg::IMU_CHANNELS)) begin
            res_o.imu_cs_action = ssps_pkg::IMU_CS_RELEASE;
            res_o.frame_done    = 1'b1;
            next_o.frame_active = 1'b0;
          end
        end
      end
    end
    res_o.imu_bus_mode = next_o.in_imu_phase;
  end

endmodule

/* hdl/spi_sensor_poll_sequencer.sv */
// spi sensor poll sequencer top level: input register, step decode, result register
// an accepted event waits in the input register and its result in the result register; an output stall holds both
// throughput: one event per cycle while the output does not stall; the step decode is a single pass of logic
// every event gives exactly one result; the state updates as it enters the result reg
// reset: asynchronous active low; pipeline empty, frame idle, adc mode, counter zero,
// channel count 8 and burst start register 32
module spi_sensor_poll_sequencer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ssps_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ssps_pkg::out_t            out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [ssps_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic             a_valid_q;
  ssps_pkg::in_t    a_data_q;
  logic             out_valid_q;
  ssps_pkg::out_t   out_q;
  ssps_pkg::state_t state_q;
  ssps_pkg::cfg_t   cfg_q;
  ssps_pkg::out_t   step_res;
  ssps_pkg::state_t step_next;
  logic             out_ready;
  logic             a_move;
  logic             in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign a_move     = a_valid_q && out_ready;
  assign in_stall_o = a_valid_q && !a_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  ssps_step u_step (
    .item_i  (a_data_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .res_o   (step_res),
    .next_o  (step_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_accept) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else if (a_move) begin
      out_valid_q <= 1'b1;
      state_q     <= step_next;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      out_q <= step_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_channel_count        <= ssps_pkg::ADC_COUNT_RESET;
      cfg_q.imu_burst_start_register <= ssps_pkg::IMU_START_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ssps_pkg::REG_ADC_COUNT: begin
          cfg_q.adc_channel_count <= cfg_wdata_i[ssps_pkg::ACNT_W-1:0];
        end
        ssps_pkg::REG_IMU_START: begin
          cfg_q.imu_burst_start_register <= cfg_wdata_i[ssps_pkg::IMUREG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a finished frame leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_move && step_res.frame_done) |=> !state_q.frame_active)
    else $error("frame_done without idle state");

  // reported bus mode tracks the phase held in state
  a_bus_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move |=> (out_q.imu_bus_mode == state_q.in_imu_phase))
    else $error("bus mode differs from phase");

  // a transfer into the result register never coincides with a held result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !a_move)
    else $error("held result overwritten");

endmodule
